// ----- hdl/mi3_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths, cofactor index tables and pipeline depths for the
// 3x3 adjugate matrix inverse. No dependencies.
package mi3_pkg;

  localparam int EW  = 32;  // element width, Q16.16
  localparam int NEL = 9;   // elements per matrix
  localparam int PW  = 64;  // 32x32 product, also cofactor magnitude
  localparam int CW  = 65;  // signed cofactor, Q32.32
  localparam int TW  = 98;  // signed determinant, Q48.48
  localparam int MW  = 97;  // determinant magnitude
  localparam int DDW = 98;  // divisor (2 * |det|)
  localparam int NW  = 99;  // dividend / partial remainder
  localparam int QB  = 33;  // quotient bits produced per lane
  localparam int WW  = NW + QB - 1;  // compare width for shifted divisor
  localparam int DRW = MW - 15;      // rounded determinant before saturation
  localparam int DQW = 64;           // determinant output width

  localparam int LAT_COF  = 2;
  localparam int LAT_DET  = 4;
  localparam int LAT_LANE = QB + 2;
  localparam int NS       = LAT_COF + LAT_DET + LAT_LANE + 1;

  localparam logic [EW-1:0]  INV_MAX = 32'h7FFF_FFFF;
  localparam logic [EW-1:0]  INV_MIN = 32'h8000_0000;
  localparam logic [DQW-1:0] DET_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DQW-1:0] DET_MIN = 64'h8000_0000_0000_0000;

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic [PW-1:0]        mag_t;
  typedef logic [MW-1:0]        dmag_t;

  // transposed cofactor k = a[P]*a[Q] - a[R]*a[S], elements in row-major order
  localparam logic [3:0] COF_P [NEL] = '{4'd4, 4'd7, 4'd1, 4'd5, 4'd8, 4'd2, 4'd3, 4'd6, 4'd0};
  localparam logic [3:0] COF_Q [NEL] = '{4'd8, 4'd2, 4'd5, 4'd6, 4'd0, 4'd3, 4'd7, 4'd1, 4'd4};
  localparam logic [3:0] COF_R [NEL] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd6, 4'd5, 4'd6, 4'd7, 4'd1};
  localparam logic [3:0] COF_S [NEL] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd2, 4'd0, 4'd4, 4'd0, 4'd3};

endpackage

// ----- hdl/matrix_inverse_3x3.sv -----
`timescale 1ns / 1ps
// 3x3 matrix inverse by the adjugate, Q16.16 in, Q16.16 inverse out.
// Depends on mi3_pkg, mi3_cof, mi3_det, mi3_lane.
//
// Usage:
//   Input stream s_*: one beat carries one matrix, nine signed Q16.16
//   elements in row-major order. Output stream m_*: one beat per matrix,
//   nine inverse elements (Q16.16, rounded to nearest, saturated), the
//   determinant (Q32.32, rounded, saturated) and a singular flag in tuser.
//   A zero determinant gives singular = 1, zero inverse and zero determinant.
//
// Timing:
//   From an accepted input beat to m_tvalid the stages are: 2 for
//   the cofactors, 4 for the determinant, 35 for the nine divider lanes
//   (one quotient bit per stage) and 1 for the saturating merge stage.
//   Throughput is one matrix per cycle while m_tready is high; every stage is registered.
//
// Reset and stall:
//   rst clears all stage valid bits; data registers are not reset.
//   Each stage holds while the next one is full and stalled, so when
//   m_tready is low the pipe keeps filling its bubbles and s_tready only
//   drops once every stage holds a beat. No beat is dropped or repeated.
module matrix_inverse_3x3 import mi3_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [287:0]   s_tdata,   // a_xx, a_xy, a_xz, a_yx, a_yy, a_yz, a_zx, a_zy, a_zz
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [351:0]   m_tdata,   // inv_xx .. inv_zz (32b each), determinant (64b)
  output logic [0:0]     m_tuser    // singular
);

  localparam int LB  = LAT_COF + LAT_DET;  // first lane stage
  localparam int DLY = LAT_LANE - 2;       // determinant delay stages

  // per-stage valid and advance; a stage advances if empty or the next moves
  logic [NS-1:0] vld;
  logic [NS:0]   go;

  assign go[NS] = m_tready;
  for (genvar k = 0; k < NS; k++) begin : g_go
    assign go[k] = ~vld[k] | go[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (go[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < NS; k++)
        if (go[k]) vld[k] <= vld[k-1];
    end
  end

  assign s_tready = go[0];
  assign m_tvalid = vld[NS-1];

  elem_t a_in [NEL];
  for (genvar k = 0; k < NEL; k++) begin : g_unpack
    assign a_in[k] = s_tdata[EW*k +: EW];
  end

  elem_t          a_q [NEL];
  cof_t           cof [NEL];
  mag_t           cm  [NEL];
  logic [NEL-1:0] cneg;
  dmag_t          dmag;
  logic           dneg;
  logic           dzero;

  mi3_cof u_cof (
    .clk (clk),
    .go  (go[LAT_COF-1:0]),
    .a   (a_in),
    .a_q (a_q),
    .cof (cof)
  );

  mi3_det u_det (
    .clk   (clk),
    .go    (go[LB-1:LAT_COF]),
    .a     (a_q),
    .cof   (cof),
    .cm    (cm),
    .cneg  (cneg),
    .dmag  (dmag),
    .dneg  (dneg),
    .dzero (dzero)
  );

  // nine divider lanes side by side
  logic [QB-1:0]  quo [NEL];
  logic [NEL-1:0] l_ovf;
  logic [NEL-1:0] l_neg;

  for (genvar k = 0; k < NEL; k++) begin : g_lane
    mi3_lane u_lane (
      .clk  (clk),
      .go   (go[LB+LAT_LANE-1:LB]),
      .cm   (cm[k]),
      .cneg (cneg[k]),
      .dmag (dmag),
      .dneg (dneg),
      .quo  (quo[k]),
      .ovf  (l_ovf[k]),
      .neg  (l_neg[k])
    );
  end

  // determinant rounding runs beside the lanes
  logic [MW:0]     dsum;
  logic [DRW-1:0]  dr;
  logic            dr_neg;
  logic            dr_zero;
  logic [DQW-1:0]  dq7;
  logic            dz7;
  logic [DQW-1:0]  dq_d [DLY];
  logic [DLY-1:0]  dz_d;

  assign dsum = {1'b0, dmag} + (MW+1)'(32'h8000);

  always_ff @(posedge clk) begin
    if (go[LB]) begin
      dr      <= dsum[MW:16];
      dr_neg  <= dneg;
      dr_zero <= dzero;
    end
    if (go[LB+1]) begin
      dz7 <= dr_zero;
      if (!dr_neg)
        dq7 <= (|dr[DRW-1:DQW-1]) ? DET_MAX : dr[DQW-1:0];
      else if ((|dr[DRW-1:DQW]) || (dr[DQW-1] && (|dr[DQW-2:0])))
        dq7 <= DET_MIN;
      else
        dq7 <= -dr[DQW-1:0];
    end
  end

  for (genvar s = 0; s < DLY; s++) begin : g_dly
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (go[LB+2]) begin
          dq_d[0] <= dq7;
          dz_d[0] <= dz7;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (go[LB+2+s]) begin
          dq_d[s] <= dq_d[s-1];
          dz_d[s] <= dz_d[s-1];
        end
      end
    end
  end

  // merge: sign, saturation and the singular override
  logic [EW*NEL-1:0] inv_w;

  always_comb begin
    for (int k = 0; k < NEL; k++) begin
      if (dz_d[DLY-1])
        inv_w[EW*k +: EW] = '0;
      else if (!l_neg[k])
        inv_w[EW*k +: EW] = (l_ovf[k] | quo[k][QB-1] | quo[k][EW-1]) ? INV_MAX
                                                                     : quo[k][EW-1:0];
      else if (l_ovf[k] | quo[k][QB-1] | (quo[k][EW-1] & (|quo[k][EW-2:0])))
        inv_w[EW*k +: EW] = INV_MIN;
      else
        inv_w[EW*k +: EW] = -quo[k][EW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (go[NS-1]) begin
      m_tdata <= {dz_d[DLY-1] ? {DQW{1'b0}} : dq_d[DLY-1], inv_w};
      m_tuser <= dz_d[DLY-1];
    end
  end

endmodule

// ----- hdl/mi3_cof.sv -----
`timescale 1ns / 1ps
// Cofactor stages: eighteen 32x32 products, then nine exact 2x2 cofactors.
// Depends on mi3_pkg.
module mi3_cof import mi3_pkg::*; (
  input  logic               clk,
  input  logic [LAT_COF-1:0] go,
  input  elem_t              a     [NEL],
  output elem_t              a_q   [NEL],
  output cof_t               cof   [NEL]
);

  logic signed [PW-1:0] pa [NEL];
  logic signed [PW-1:0] pb [NEL];
  elem_t                a0 [NEL];

  always_ff @(posedge clk) begin
    if (go[0]) begin
      for (int k = 0; k < NEL; k++) begin
        pa[k] <= PW'(a[COF_P[k]]) * PW'(a[COF_Q[k]]);
        pb[k] <= PW'(a[COF_R[k]]) * PW'(a[COF_S[k]]);
        a0[k] <= a[k];
      end
    end
    if (go[1]) begin
      for (int k = 0; k < NEL; k++) begin
        cof[k] <= CW'(pa[k]) - CW'(pb[k]);
        a_q[k] <= a0[k];
      end
    end
  end

endmodule

// ----- hdl/mi3_det.sv -----
`timescale 1ns / 1ps
// Determinant by first-row expansion (split 32x33 products), then sign and
// magnitude of the determinant and of every cofactor. Depends on mi3_pkg.
module mi3_det import mi3_pkg::*; (
  input  logic               clk,
  input  logic [LAT_DET-1:0] go,
  input  elem_t              a     [NEL],
  input  cof_t               cof   [NEL],
  output mag_t               cm    [NEL],
  output logic [NEL-1:0]     cneg,
  output dmag_t              dmag,
  output logic               dneg,
  output logic               dzero
);

  logic signed [CW-1:0] phi  [3];
  logic signed [CW-1:0] plo  [3];
  logic signed [TW-1:0] term [3];
  logic signed [TW-1:0] det;
  cof_t                 c2 [NEL];
  cof_t                 c3 [NEL];
  cof_t                 c4 [NEL];

  always_ff @(posedge clk) begin
    if (go[0]) begin
      for (int t = 0; t < 3; t++) begin
        phi[t] <= CW'(a[t]) * CW'($signed(cof[3*t][CW-1:EW]));
        plo[t] <= CW'(a[t]) * CW'($signed({1'b0, cof[3*t][EW-1:0]}));
      end
      c2 <= cof;
    end
    if (go[1]) begin
      for (int t = 0; t < 3; t++)
        term[t] <= (TW'(phi[t]) <<< EW) + TW'(plo[t]);
      c3 <= c2;
    end
    if (go[2]) begin
      det <= term[0] + term[1] + term[2];
      c4  <= c3;
    end
    if (go[3]) begin
      dneg  <= det[TW-1];
      dmag  <= MW'(det[TW-1] ? -det : det);
      dzero <= (det == '0);
      for (int k = 0; k < NEL; k++) begin
        cm[k]   <= PW'(c4[k][CW-1] ? -c4[k] : c4[k]);
        cneg[k] <= c4[k][CW-1];
      end
    end
  end

endmodule

// ----- hdl/mi3_lane.sv -----
`timescale 1ns / 1ps
// One divider lane: round(|c| * 2^32 / |d|) as a pipelined restoring divide,
// one quotient bit per stage, with an overflow flag. Depends on mi3_pkg.
module mi3_lane import mi3_pkg::*; (
  input  logic                clk,
  input  logic [LAT_LANE-1:0] go,
  input  mag_t                cm,
  input  logic                cneg,
  input  dmag_t               dmag,
  input  logic                dneg,
  output logic [QB-1:0]       quo,
  output logic                ovf,
  output logic                neg
);

  localparam int NUM_SH = 33;  // |c| * 2^32 * 2, rounding by +|d| over 2|d|

  logic [NW-1:0]  n0;
  logic [DDW-1:0] d0;
  logic           neg0;
  logic [NW-1:0]  r  [QB];
  logic [DDW-1:0] dd [QB];
  logic [QB-1:0]  q  [QB+1];
  logic [QB:0]    ovf_v;
  logic [QB:0]    neg_v;

  always_ff @(posedge clk) begin
    if (go[0]) begin
      n0   <= NW'({cm, {NUM_SH{1'b0}}}) + NW'(dmag);
      d0   <= {dmag, 1'b0};
      neg0 <= cneg ^ dneg;
    end
    if (go[1]) begin
      ovf_v[0] <= WW'(n0) >= (WW'(d0) << QB);
      r[0]     <= n0;
      dd[0]    <= d0;
      q[0]     <= '0;
      neg_v[0] <= neg0;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_bit
    localparam int SH = QB - 1 - j;
    logic [WW-1:0] dsh;
    logic          ge;

    assign dsh = WW'(dd[j]) << SH;
    assign ge  = WW'(r[j]) >= dsh;

    always_ff @(posedge clk) begin
      if (go[j+2]) begin
        q[j+1]       <= {q[j][QB-2:0], ge};
        ovf_v[j+1]   <= ovf_v[j];
        neg_v[j+1]   <= neg_v[j];
      end
    end

    if (j < QB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (go[j+2]) begin
          r[j+1]  <= ge ? NW'(WW'(r[j]) - dsh) : r[j];
          dd[j+1] <= dd[j];
        end
      end
    end
  end

  assign quo = q[QB];
  assign ovf = ovf_v[QB];
  assign neg = neg_v[QB];

endmodule
